[sv/cgp_pkg.sv]
// Package: shared types, codes and helpers for the composite glyph component parser.
package cgp_pkg;

  // Parser phases within one glyph record
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_BBOX   = 3'd1,
    PH_FLAGS  = 3'd2,
    PH_GID    = 3'd3,
    PH_SKIP   = 3'd4,
    PH_IGNORE = 3'd5
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_COMPONENT = 2'd0,
    ST_CLEAN     = 2'd1,
    ST_TRUNC     = 2'd2
  } status_t;

  // Component flag bits
  localparam logic [15:0] FLG_ARGS_WORDS = 16'h0001;
  localparam logic [15:0] FLG_HAVE_SCALE = 16'h0008;
  localparam logic [15:0] FLG_XY_SCALE   = 16'h0040;
  localparam logic [15:0] FLG_TWO_BY_TWO = 16'h0080;
  localparam logic [15:0] FLG_MORE_COMP  = 16'h0020;
  localparam logic [15:0] HDR_SIGN       = 16'h8000;

  // Bounding box length in bytes
  localparam logic [3:0] BBOX_BYTES = 4'(2 * 4);

  // One result item
  typedef struct packed {
    status_t     status;
    logic [15:0] component_gid;
    logic        last_of_glyph;
  } result_t;

  // Argument plus scale bytes that follow the glyph id
  function automatic logic [3:0] skip_for(input logic [15:0] f);
    logic [3:0] n;
    n = ((f & FLG_ARGS_WORDS) != 16'h0) ? 4'd4 : 4'd2;
    if ((f & FLG_HAVE_SCALE) != 16'h0) begin
      n = n + 4'd2;
    end else if ((f & FLG_XY_SCALE) != 16'h0) begin
      n = n + 4'd4;
    end else if ((f & FLG_TWO_BY_TWO) != 16'h0) begin
      n = n + 4'd8;
    end
    return n;
  endfunction

endpackage

[sv/composite_glyph_component_parser.sv]
// Top level: composite glyph component parser, one glyph byte per request.
// A result is registered and appears on out_valid in the cycle after the byte that causes it.
// Throughput: one byte per cycle while in_ready is high; the single result register refills in the cycle it drains.
// in_ready drops only while a result sits unread and out_ready is low.
// Reset (rst_n low, synchronous) returns the parser to the header phase, empties the result.
module composite_glyph_component_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_glyph_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_component_gid,
  output logic        out_last_of_glyph
);
  import cgp_pkg::*;

  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign take = in_valid && in_ready;

  cgp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .glyph_end (in_glyph_end),
    .res_valid (res_valid),
    .res       (res)
  );

  cgp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && res_valid),
    .res       (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_component_gid = out_res.component_gid;
  assign out_last_of_glyph = out_res.last_of_glyph;

endmodule

[sv/cgp_parser.sv]
// Parser state registers and per-byte decode logic.
module cgp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [7:0]       data_byte,
  input  logic             glyph_end,
  output logic             res_valid,
  output cgp_pkg::result_t res
);
  import cgp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  byte_count_r, byte_count_nxt;
  logic [15:0] flag_word_r, flag_word_nxt;
  logic [15:0] gid_word_r, gid_word_nxt;
  logic [3:0]  skip_left_r, skip_left_nxt;
  logic        done_flag_r, done_flag_nxt;

  logic [15:0] word_lo;
  logic [3:0]  bbox_cnt;
  logic [3:0]  skip_dec;
  logic        more;

  assign word_lo  = flag_word_r | {8'h00, data_byte};
  assign bbox_cnt = byte_count_r + 4'd1;
  assign skip_dec = (skip_left_r != 4'd0) ? (skip_left_r - 4'd1) : skip_left_r;
  assign more     = (flag_word_r & FLG_MORE_COMP) != 16'h0;

  // Decode one byte and pick the result
  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    flag_word_nxt  = flag_word_r;
    gid_word_nxt   = gid_word_r;
    skip_left_nxt  = skip_left_r;
    done_flag_nxt  = done_flag_r;
    res_valid      = 1'b0;
    res.status        = ST_TRUNC;
    res.component_gid = 16'h0;
    res.last_of_glyph = 1'b1;

    unique case (phase_r)
      PH_HEADER: begin
        if (byte_count_r == 4'd0) begin
          flag_word_nxt  = {data_byte, 8'h00};
          byte_count_nxt = 4'd1;
          res_valid      = glyph_end;
        end else begin
          flag_word_nxt  = word_lo;
          byte_count_nxt = 4'd0;
          res_valid      = glyph_end;
          if ((word_lo & HDR_SIGN) == 16'h0) begin
            phase_nxt  = PH_IGNORE;
            res.status = ST_CLEAN;
          end else begin
            phase_nxt  = PH_BBOX;
          end
        end
      end
      PH_BBOX: begin
        byte_count_nxt = bbox_cnt;
        res_valid      = glyph_end;
        if (bbox_cnt >= BBOX_BYTES) begin
          byte_count_nxt = 4'd0;
          phase_nxt      = PH_FLAGS;
          res.status     = ST_CLEAN;
        end
      end
      PH_FLAGS: begin
        res_valid = glyph_end;
        if (byte_count_r == 4'd0) begin
          flag_word_nxt  = {data_byte, 8'h00};
          byte_count_nxt = 4'd1;
        end else begin
          flag_word_nxt  = word_lo;
          byte_count_nxt = 4'd0;
          phase_nxt      = PH_GID;
        end
      end
      PH_GID: begin
        res_valid = glyph_end;
        if (byte_count_r == 4'd0) begin
          gid_word_nxt   = {data_byte, 8'h00};
          byte_count_nxt = 4'd1;
        end else begin
          gid_word_nxt   = gid_word_r | {8'h00, data_byte};
          byte_count_nxt = 4'd0;
          skip_left_nxt  = skip_for(flag_word_r);
          phase_nxt      = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_left_nxt = skip_dec;
        if (skip_dec == 4'd0) begin
          res_valid         = 1'b1;
          res.status        = ST_COMPONENT;
          res.component_gid = gid_word_r;
          res.last_of_glyph = !more || glyph_end;
          if (more) begin
            phase_nxt = PH_FLAGS;
          end else begin
            phase_nxt     = PH_IGNORE;
            done_flag_nxt = 1'b1;
          end
        end else begin
          res_valid = glyph_end;
        end
      end
      default: begin
        // Ignore phase and unused codes
        res_valid  = glyph_end && !done_flag_r;
        res.status = ST_CLEAN;
      end
    endcase

    // Drop all state at the end of a glyph
    if (glyph_end) begin
      phase_nxt      = PH_HEADER;
      byte_count_nxt = 4'd0;
      flag_word_nxt  = 16'h0;
      gid_word_nxt   = 16'h0;
      skip_left_nxt  = 4'd0;
      done_flag_nxt  = 1'b0;
    end
  end

  // Advance state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      byte_count_r <= 4'd0;
      flag_word_r  <= 16'h0;
      gid_word_r   <= 16'h0;
      skip_left_r  <= 4'd0;
      done_flag_r  <= 1'b0;
    end else if (take) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      flag_word_r  <= flag_word_nxt;
      gid_word_r   <= gid_word_nxt;
      skip_left_r  <= skip_left_nxt;
      done_flag_r  <= done_flag_nxt;
    end
  end

endmodule

[sv/cgp_out_reg.sv]
// Result register with valid/ready handshake toward the consumer.
module cgp_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cgp_pkg::result_t res,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output cgp_pkg::result_t out_res
);
  import cgp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Take a new request whenever the slot is empty or drains this cycle
  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[sv/cgp_checker.sv]
// Port-level checker for the composite glyph component parser, with its bind.
module cgp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_component_gid,
  input logic        out_last_of_glyph
);
  import cgp_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_component_gid) && $stable(out_last_of_glyph))
    else $error("stalled result changed");

  // Status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_COMPONENT || out_status == ST_CLEAN
      || out_status == ST_TRUNC)
    else $error("undefined status code");

  // Clean and truncated results close the glyph and carry no glyph id
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_COMPONENT
      |-> out_last_of_glyph && out_component_gid == 16'h0)
    else $error("end result with glyph id or without last mark");

  // Input side never stalls while the result slot is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free result slot");

endmodule

bind composite_glyph_component_parser cgp_checker u_cgp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_component_gid (out_component_gid),
  .out_last_of_glyph (out_last_of_glyph)
);
